// File: sv/gcls_pkg.sv
// Package for grid cell latency statistics: sizes, item types, shared types.
// Used by gcls_front, gcls_back and grid_cell_latency_stats_core.
package gcls_pkg;
  localparam int ScreenWidth  = 1024;
  localparam int ScreenHeight = 600;
  localparam int Cells        = 9;
  localparam logic [15:0] Max16 = 16'hFFFF;

  // classified item passed from front to back
  typedef struct packed {
    logic        clear_stats;
    logic [3:0]  grid_bin;
    logic [15:0] rt;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  hit_cell;
    logic [15:0] cell_hits;
    logic [15:0] cell_mean_ms;
    logic [15:0] cell_fastest_ms;
    logic [15:0] cell_slowest_ms;
    logic [15:0] all_hits;
    logic [15:0] all_mean_ms;
    logic [15:0] all_fastest_ms;
    logic [15:0] all_slowest_ms;
    logic        weak_found;
    logic [3:0]  weak_cell;
    logic [15:0] weak_mean_ms;
  } result_t;

  // grid coordinate of one clamped axis: (c*3)/size compared as c*3 >= k*size
  function automatic logic [1:0] grid_axis(input logic signed [15:0] pos,
                                           input logic [12:0] size);
    logic [12:0] c;
    logic [14:0] c3;
    begin
      if (pos[15]) c = '0;
      else if ({1'b0, pos} >= {4'b0, size}) c = size - 13'd1;
      else c = pos[12:0];
      c3 = {c, 1'b0} + {2'b0, c};
      if (c3 >= {size, 1'b0}) grid_axis = 2'd2;
      else if (c3 >= {2'b0, size}) grid_axis = 2'd1;
      else grid_axis = 2'd0;
    end
  endfunction
endpackage

// File: sv/grid_cell_latency_stats_core.sv
// Grid cell latency statistics top level. Each item passes the front queue, then
// eleven passes of the bit-serial divider (cell mean, total mean, nine cell
// means), then sequencing and output. A new item enters the back part only after
// the last result is accepted; the front queue takes two items ahead.
// Synchronous active-high reset clears all statistics to empty values.
// Depends on gcls_pkg, gcls_front, gcls_back.
module grid_cell_latency_stats_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,  // x_position, y_position, latency
  input  logic         s_tuser,  // clear_stats
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit_cell, cell_hits, cell_mean_ms, cell_fastest_ms, cell_slowest_ms,
  // all_hits, all_mean_ms, all_fastest_ms, all_slowest_ms, weak_found,
  // weak_cell, weak_mean_ms
  output logic [167:0] m_tdata
);
  logic q_valid, q_ready;
  gcls_pkg::cmd_t q_cmd;
  gcls_pkg::result_t r;
  logic m_valid_i;
  logic out_seen;

  gcls_front u_front (.clk, .rst, .s_valid(s_tvalid), .s_ready(s_tready),
    .in_clear(s_tuser), .in_x(s_tdata[15:0]), .in_y(s_tdata[31:16]),
    .in_rt(s_tdata[47:32]), .q_valid, .q_ready, .q_cmd);

  gcls_back u_back (.clk, .rst, .q_valid, .q_ready, .q_cmd,
    .r_valid(m_valid_i), .r_ready(m_tready && out_seen), .r_data(r));

  // S_OUT registers the weak fields, so valid is held back to the cycle after S_OUT begins
  always_ff @(posedge clk) begin
    if (rst) out_seen <= 1'b0;
    else out_seen <= m_valid_i && !(m_tvalid && m_tready);
  end
  assign m_tvalid = m_valid_i && out_seen;

  assign m_tdata = {15'b0, r.weak_mean_ms, r.weak_cell, r.weak_found,
    r.all_slowest_ms, r.all_fastest_ms, r.all_mean_ms, r.all_hits,
    r.cell_slowest_ms, r.cell_fastest_ms, r.cell_mean_ms, r.cell_hits,
    r.hit_cell};
endmodule

// File: sv/gcls_front.sv
// Front part: accepts input items, bins the coordinate and fixes up latency.
// Depends on gcls_pkg. Feeds a two-entry queue toward the back part.
module gcls_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  logic           in_clear,
  input  logic [15:0]    in_x,
  input  logic [15:0]    in_y,
  input  logic [15:0]    in_rt,
  output logic           q_valid,
  input  logic           q_ready,
  output gcls_pkg::cmd_t q_cmd
);
  gcls_pkg::cmd_t mem [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  gcls_pkg::cmd_t cmd;
  logic [1:0] gx, gy;
  logic push, pop;

  // classification
  always_comb begin
    gx = gcls_pkg::grid_axis(in_x, 13'(gcls_pkg::ScreenWidth));
    gy = gcls_pkg::grid_axis(in_y, 13'(gcls_pkg::ScreenHeight));
    cmd.clear_stats = in_clear;
    cmd.grid_bin = in_clear ? 4'd0 : ({2'b0, gy} + {gy, 2'b0} - {2'b0, gy} - {2'b0, gy}
                                      + {2'b0, gx});
    cmd.rt = (in_rt == 16'd0) ? 16'd1 : in_rt;
  end

  assign s_ready = (fill != 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_cmd   = mem[rd_ptr];
  assign push    = s_valid && s_ready;
  assign pop     = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cmd;
  end

  // queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: sv/gcls_div.sv
// Restoring divider, one quotient bit a cycle: 32-bit sum over 16-bit count.
// Self-contained; quotient truncated to 16 bits, zero when count is zero.
module gcls_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [15:0] quo
);
  logic [31:0] q;
  logic [15:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic [15:0] d;

  assign trial = {rem, q[31]} - {1'b0, d};
  assign quo   = (d == 16'd0) ? 16'd0 : q[15:0];

  // shift-subtract iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
        q <= num;
        d <= den;
        rem <= '0;
      end else if (busy) begin
        if (!trial[16]) begin
          rem <= trial[15:0];
          q <= {q[30:0], 1'b1};
        end else begin
          rem <= {rem[14:0], q[31]};
          q <= {q[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: sv/gcls_back.sv
// Back part: updates per-cell and total statistics, then rescans the cells
// for the weakest mean with one shared divider. Depends on gcls_pkg, gcls_div.
module gcls_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  gcls_pkg::cmd_t    q_cmd,
  output logic              r_valid,
  input  logic              r_ready,
  output gcls_pkg::result_t r_data
);
  typedef enum logic [2:0] {S_IDLE, S_UPD, S_CELL, S_ALL, S_SCAN, S_OUT} state_t;
  state_t state;

  logic [15:0] cnt [gcls_pkg::Cells];
  logic [31:0] sum [gcls_pkg::Cells];
  logic [15:0] mn  [gcls_pkg::Cells];
  logic [15:0] mx  [gcls_pkg::Cells];
  logic [15:0] tcnt, gmin, gmax;
  logic [31:0] tsum;
  gcls_pkg::cmd_t cur;
  logic [3:0] idx;
  logic       wv;
  logic [3:0] wi;
  logic [15:0] wm;

  logic        d_start, d_done;
  logic [31:0] d_num;
  logic [15:0] d_den, d_quo;

  gcls_div u_div (.clk, .rst, .start(d_start), .num(d_num), .den(d_den),
                  .done(d_done), .quo(d_quo));

  assign q_ready = (state == S_IDLE);
  assign r_valid = (state == S_OUT);

  // divider operand select
  always_comb begin
    d_start = 1'b0;
    d_num = sum[cur.grid_bin];
    d_den = cnt[cur.grid_bin];
    unique case (state)
      S_UPD: d_start = 1'b1;
      S_CELL: begin
        d_num = tsum;
        d_den = tcnt;
        d_start = d_done;
      end
      S_ALL: begin
        d_num = sum[0];
        d_den = cnt[0];
        d_start = d_done;
      end
      S_SCAN: begin
        d_num = sum[idx + 4'd1];
        d_den = cnt[idx + 4'd1];
        d_start = d_done && (idx != 4'd8);
      end
      default: ;
    endcase
  end

  // sequencer and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < gcls_pkg::Cells; i++) begin
        cnt[i] <= '0; sum[i] <= '0; mn[i] <= gcls_pkg::Max16; mx[i] <= '0;
      end
      tcnt <= '0; tsum <= '0; gmin <= gcls_pkg::Max16; gmax <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          cur <= q_cmd;
          if (q_cmd.clear_stats) begin
            for (int i = 0; i < gcls_pkg::Cells; i++) begin
              cnt[i] <= '0; sum[i] <= '0; mn[i] <= gcls_pkg::Max16; mx[i] <= '0;
            end
            tcnt <= '0; tsum <= '0; gmin <= gcls_pkg::Max16; gmax <= '0;
          end else begin
            if (cnt[q_cmd.grid_bin] != gcls_pkg::Max16) begin
              cnt[q_cmd.grid_bin] <= cnt[q_cmd.grid_bin] + 16'd1;
              sum[q_cmd.grid_bin] <= sum[q_cmd.grid_bin] + {16'b0, q_cmd.rt};
            end
            if (q_cmd.rt < mn[q_cmd.grid_bin]) mn[q_cmd.grid_bin] <= q_cmd.rt;
            if (q_cmd.rt > mx[q_cmd.grid_bin]) mx[q_cmd.grid_bin] <= q_cmd.rt;
            if (tcnt != gcls_pkg::Max16) begin
              tcnt <= tcnt + 16'd1;
              tsum <= tsum + {16'b0, q_cmd.rt};
            end
            if (q_cmd.rt < gmin) gmin <= q_cmd.rt;
            if (q_cmd.rt > gmax) gmax <= q_cmd.rt;
          end
          state <= S_UPD;
        end
        S_UPD: begin
          state <= S_CELL;
          r_data.hit_cell <= cur.grid_bin;
          r_data.cell_hits <= cnt[cur.grid_bin];
          r_data.cell_fastest_ms <= mn[cur.grid_bin];
          r_data.cell_slowest_ms <= mx[cur.grid_bin];
          r_data.all_hits <= tcnt;
          r_data.all_fastest_ms <= gmin;
          r_data.all_slowest_ms <= gmax;
        end
        S_CELL: if (d_done) begin
          r_data.cell_mean_ms <= d_quo;
          state <= S_ALL;
        end
        S_ALL: if (d_done) begin
          r_data.all_mean_ms <= d_quo;
          idx <= '0;
          wv <= 1'b0; wi <= '0; wm <= '0;
          state <= S_SCAN;
        end
        S_SCAN: if (d_done) begin
          if (cnt[idx] != 16'd0 && (!wv || d_quo > wm)) begin
            wv <= 1'b1; wi <= idx; wm <= d_quo;
          end
          if (idx == 4'd8) state <= S_OUT;
          else idx <= idx + 4'd1;
        end
        S_OUT: begin
          r_data.weak_found <= wv;
          r_data.weak_cell <= wi;
          r_data.weak_mean_ms <= wm;
          if (r_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: dv/tb_grid_cell_latency_stats_core.sv
// Self-checking testbench for grid_cell_latency_stats_core: hit and clear items
// are predicted by a local statistics model and compared with every result.
// Depends on gcls_pkg and the grid_cell_latency_stats_core RTL.
`timescale 1ns / 100ps

module tb_grid_cell_latency_stats_core;

  localparam int NumFields = 12;
  localparam int ResBits = 153;
  localparam int CycleLimit = 4000000;
  localparam int DrainCycles = 1000;
  // result layout, lowest field first
  localparam int FieldLo[NumFields] = '{0, 4, 20, 36, 52, 68, 84, 100, 116, 132, 133, 137};
  localparam int FieldW[NumFields] = '{4, 16, 16, 16, 16, 16, 16, 16, 16, 1, 4, 16};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [167:0] m_tdata;

  // model of the statistics held in the block
  logic [15:0] bin_hits[gcls_pkg::Cells];
  logic [31:0] bin_total[gcls_pkg::Cells];
  logic [15:0] bin_fast[gcls_pkg::Cells];
  logic [15:0] bin_slow[gcls_pkg::Cells];
  logic [15:0] grand_hits;
  logic [31:0] grand_total;
  logic [15:0] grand_fast;
  logic [15:0] grand_slow;

  logic [ResBits-1:0] pending_stats[$];
  int mismatches = 0;
  int cycles = 0;
  bit steady = 0;  // no idling on either side while set

  grid_cell_latency_stats_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int axis_bin(input logic signed [15:0] pos, input int size);
    int c;
    int g;
    begin
      c = pos;
      if (c < 0) c = 0;
      if (c > size - 1) c = size - 1;
      g = (c * 3) / size;
      if (g > 2) g = 2;
      axis_bin = g;
    end
  endfunction

  function automatic logic [15:0] avg(input logic [31:0] s, input logic [15:0] n);
    avg = (n == 0) ? 16'd0 : 16'((s / n));
  endfunction

  task automatic clear_model();
    for (int i = 0; i < gcls_pkg::Cells; i++) begin
      bin_hits[i] = '0;
      bin_total[i] = '0;
      bin_fast[i] = gcls_pkg::Max16;
      bin_slow[i] = '0;
    end
    grand_hits = '0;
    grand_total = '0;
    grand_fast = gcls_pkg::Max16;
    grand_slow = '0;
  endtask

  // update the model with one item and queue the expected result
  task automatic predict_stats(input logic clr, input logic [47:0] d);
    int grid_bin;
    logic [15:0] rt;
    logic [15:0] m;
    logic [31:0] f[NumFields];
    logic [ResBits-1:0] r;
    bit found;
    int wi;
    logic [15:0] wm;
    begin
      grid_bin = 0;
      if (clr) begin
        clear_model();
      end else begin
        grid_bin = axis_bin(d[31:16], gcls_pkg::ScreenHeight) * 3
                   + axis_bin(d[15:0], gcls_pkg::ScreenWidth);
        rt = (d[47:32] == 0) ? 16'd1 : d[47:32];
        if (bin_hits[grid_bin] < gcls_pkg::Max16) begin
          bin_hits[grid_bin]++;
          bin_total[grid_bin] += rt;
        end
        if (rt < bin_fast[grid_bin]) bin_fast[grid_bin] = rt;
        if (rt > bin_slow[grid_bin]) bin_slow[grid_bin] = rt;
        if (grand_hits < gcls_pkg::Max16) begin
          grand_hits++;
          grand_total += rt;
        end
        if (rt < grand_fast) grand_fast = rt;
        if (rt > grand_slow) grand_slow = rt;
      end
      // weakest cell: highest mean, lowest index on ties
      found = 0;
      wi = 0;
      wm = 0;
      for (int i = 0; i < gcls_pkg::Cells; i++) begin
        if (bin_hits[i] != 0) begin
          m = avg(bin_total[i], bin_hits[i]);
          if (!found || m > wm) begin
            found = 1;
            wi = i;
            wm = m;
          end
        end
      end
      f = '{grid_bin, bin_hits[grid_bin], avg(bin_total[grid_bin], bin_hits[grid_bin]),
            bin_fast[grid_bin], bin_slow[grid_bin], grand_hits,
            avg(grand_total, grand_hits), grand_fast, grand_slow, found, wi, wm};
      r = '0;
      for (int k = 0; k < NumFields; k++)
        r |= (ResBits'(f[k]) & ((ResBits'(1) << FieldW[k]) - 1)) << FieldLo[k];
      pending_stats.push_back(r);
    end
  endtask

  // send one item, predicting it at the edge where it is taken
  task automatic send_item(input logic clr, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic [15:0] rt);
    while (!steady && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= clr;
    s_tdata <= {rt, y, x};
    do @(posedge clk); while (!s_tready);
    predict_stats(clr, {rt, y, x});
    @(negedge clk);
  endtask

  // result side: random stalls, field by field compare
  always @(negedge clk) m_tready <= steady || ($urandom_range(99) >= 11);

  always @(posedge clk) begin
    logic [ResBits-1:0] want;
    logic [ResBits-1:0] got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[ResBits-1:0];
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_stats.pop_front();
        for (int k = 0; k < NumFields; k++) begin
          if (((want ^ got) >> FieldLo[k]) & ((ResBits'(1) << FieldW[k]) - 1)) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d: expected %0h got %0h", k,
                       (want >> FieldLo[k]) & ((ResBits'(1) << FieldW[k]) - 1),
                       (got >> FieldLo[k]) & ((ResBits'(1) << FieldW[k]) - 1));
          end
        end
      end
    end
  end

  // stop sending and wait until every expected result has come
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_stats.size() != 0) @(negedge clk);
  endtask

  // corners of the coordinate range and of the latency
  task automatic test_extremes();
    send_item(1'b0, -16'sd32768, -16'sd32768, 16'd0);
    send_item(1'b0, 16'sd32767, 16'sd32767, 16'hFFFF);
    send_item(1'b0, 16'sd0, 16'sd599, 16'd1);
    send_item(1'b0, 16'sd1023, 16'sd0, 16'd5000);
    send_item(1'b0, 16'sd1024, 16'sd600, 16'd7);
    send_item(1'b0, 16'sd341, 16'sd199, 16'd300);
    send_item(1'b0, 16'sd342, 16'sd200, 16'd250);
    send_item(1'b0, 16'sd682, 16'sd399, 16'h8000);
    send_item(1'b0, 16'sd683, 16'sd400, 16'h7FFF);
    send_item(1'b0, -16'sd1, 16'sd300, 16'd0);
  endtask

  // clear drops everything, a second clear on empty stats too
  task automatic test_clear();
    send_item(1'b1, 16'sd500, 16'sd500, 16'd1234);
    send_item(1'b1, -16'sd1, -16'sd1, 16'hFFFF);
    send_item(1'b0, 16'sd900, 16'sd10, 16'd40);
  endtask

  // equal means in three cells: the lowest index is the weakest
  task automatic test_tie();
    send_item(1'b1, 16'sd0, 16'sd0, 16'd0);
    send_item(1'b0, 16'sd500, 16'sd300, 16'd100);
    send_item(1'b0, 16'sd900, 16'sd10, 16'd100);
    send_item(1'b0, 16'sd10, 16'sd590, 16'd99);
    send_item(1'b0, 16'sd10, 16'sd10, 16'd100);
  endtask

  // random hits with the odd clear; one stretch without idling and one drain pause
  task automatic test_random(input int count);
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0] rt;
    for (int n = 0; n < count; n++) begin
      steady = (n >= 300 && n < 500);
      if (n == 700) wait_drained();
      if ($urandom_range(99) < 3) begin
        send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        x = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1100) - 40);
        y = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(660) - 30);
        case ($urandom_range(3))
          0: rt = 16'($urandom);
          1: rt = 16'($urandom_range(3));
          default: rt = 16'($urandom_range(2000));
        endcase
        send_item(1'b0, x, y, rt);
      end
    end
    steady = 0;
  endtask

  initial begin
    clear_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_clear();
    test_tie();
    test_random(1130);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
